// ===== rtl/core/axis_angle_rotation_matrix_top_macros.svh =====
// Assertion macros for the axis-angle rotation matrix block
`ifndef AXIS_ANGLE_ROTATION_MATRIX_TOP_MACROS_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_TOP_MACROS_SVH

`ifndef ASSERT_OFF

`define AARM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define AARM_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define AARM_ASSERT(lbl, clk, rst_n, prop, msg)

`define AARM_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== rtl/core/aarm_pkg.sv =====
// Shared types, constants and the arctangent table for the rotation matrix block
`timescale 1ns / 1ps

package aarm_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int CORDIC_N      = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

  // root and divider chain lengths
  localparam int SQ_N  = 32;
  localparam int DIV_N = 31;

  localparam int XW = 34;
  typedef logic signed [XW-1:0] cq_t;

  typedef struct packed {
    cq_t x;
    cq_t y;
    cq_t z;
  } cordic_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [30:0] quo;
  } div_t;

  localparam cq_t GAIN_Q30 = 34'sd652032874;

  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:    v = 30'd843314856;
      5'd1:    v = 30'd497837829;
      5'd2:    v = 30'd263043836;
      5'd3:    v = 30'd133525158;
      5'd4:    v = 30'd67021686;
      5'd5:    v = 30'd33543515;
      5'd6:    v = 30'd16775850;
      5'd7:    v = 30'd8388437;
      5'd8:    v = 30'd4194282;
      5'd9:    v = 30'd2097149;
      5'd10:   v = 30'd1048575;
      5'd11:   v = 30'd524287;
      5'd12:   v = 30'd262143;
      5'd13:   v = 30'd131071;
      5'd14:   v = 30'd65535;
      5'd15:   v = 30'd32767;
      5'd16:   v = 30'd16383;
      5'd17:   v = 30'd8191;
      5'd18:   v = 30'd4095;
      5'd19:   v = 30'd2047;
      5'd20:   v = 30'd1023;
      5'd21:   v = 30'd511;
      5'd22:   v = 30'd255;
      5'd23:   v = 30'd127;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/axis_angle_rotation_matrix_top.sv =====
// Channel  Handshake                 Payload
// in       in_valid_i / in_stall_o   angle_deg_i, axis_x_i, axis_y_i, axis_z_i
// out      out_valid_o / out_stall_i m00_o .. m22_o, axis_zero_o
//
// Takes one beat per cycle while in_stall_o is low.
// Latency is set by the 32-cell square root chain followed by the 31-cell divider.
// The CORDIC row runs beside the root chain and does not add to it.
// Output register plus one skid entry: input stalls only when the skid entry is full.
// Reset clears the stage valid bits and the output/skid valid flags.
`timescale 1ns / 1ps
`include "axis_angle_rotation_matrix_top_macros.svh"

module axis_angle_rotation_matrix_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [16:0] angle_deg_i,
  input  logic signed [15:0] axis_x_i,
  input  logic signed [15:0] axis_y_i,
  input  logic signed [15:0] axis_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] m00_o,
  output logic signed [15:0] m01_o,
  output logic signed [15:0] m02_o,
  output logic signed [15:0] m10_o,
  output logic signed [15:0] m11_o,
  output logic signed [15:0] m12_o,
  output logic signed [15:0] m20_o,
  output logic signed [15:0] m21_o,
  output logic signed [15:0] m22_o,
  output logic               axis_zero_o
);
  import aarm_pkg::*;

  // stage numbering: register index after each step
  localparam int ST_N2 = 2;
  localparam int ST_TH = 4;
  localparam int ST_CS = ST_TH + CORDIC_N;
  localparam int ST_R  = ST_N2 + SQ_N;
  localparam int ST_U  = ST_R + DIV_N;
  localparam int LAST  = ST_U + 2;

  localparam logic signed [17:0] HALF_TURN    = 18'sd23040;
  localparam logic signed [17:0] FULL_TURN    = 18'sd46080;
  localparam logic signed [17:0] QUARTER_TURN = 18'sd11520;
  localparam cq_t                ONE_Q30      = 34'sd1073741824;
  localparam logic signed [15:0] ONE_Q14      = 16'sd16384;

  typedef logic [2:0][15:0] axis_t;

  typedef struct packed {
    cq_t c;
    cq_t s;
  } cs_t;

  typedef struct packed {
    logic [8:0][15:0] m;
    logic             zero;
  } res_t;

  function automatic cq_t mulq(input cq_t a, input cq_t b);
    logic signed [67:0] p;
    p = a * b + 68'sd536870912;
    return p[63:30];
  endfunction

  function automatic logic [15:0] to_q14(input cq_t a, input cq_t b, input logic sub);
    logic signed [34:0] sum;
    logic signed [34:0] q;
    logic [15:0]        r;
    sum = sub ? ({a[XW-1], a} - {b[XW-1], b}) : ({a[XW-1], a} + {b[XW-1], b});
    q   = (sum + 35'sd32768) >>> 16;
    if (q > 35'sd16384)       r = 16'd16384;
    else if (q < -35'sd16384) r = 16'hC000;
    else                      r = q[15:0];
    return r;
  endfunction

  logic en;
  logic [LAST:0] v_q;

  logic out_v_q, skid_v_q, out_free;
  res_t out_q, skid_q;

  logic signed [16:0] ang0_q;
  axis_t              ax_q [0:ST_U];

  logic signed [14:0] ang1_q;
  logic [30:0]        sq1_q [3];
  logic               flip_q [1:ST_CS];

  logic [31:0]        hi2_q, hi3_q;
  logic [27:0]        lo2_q;
  logic               neg2_q, neg3_q;
  logic [31:0]        n2_q [ST_N2:ST_N2+15];
  logic               zero_q [ST_N2:ST_U];

  logic [38:0]        p3_q;
  cordic_t            c4_q;

  cs_t                cs_q [ST_CS+1:ST_U];

  // front end signals
  logic signed [17:0] aw;
  logic               flp;
  logic signed [31:0] sqx, sqy, sqz;
  logic [14:0]        am;
  logic [13:0]        mag;
  logic [31:0]        n2_sum;
  logic [31:0]        th;
  cq_t                th_s;

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAST-1:0], in_valid_i};
    end
  end

  // angle wrap and quarter-turn fold, axis squares
  always_comb begin
    aw  = {ang0_q[16], ang0_q};
    flp = 1'b0;
    if (aw >= HALF_TURN) aw = aw - FULL_TURN;
    else if (aw < -HALF_TURN) aw = aw + FULL_TURN;
    if (aw > QUARTER_TURN) begin
      aw  = aw - HALF_TURN;
      flp = 1'b1;
    end else if (aw < -QUARTER_TURN) begin
      aw  = aw + HALF_TURN;
      flp = 1'b1;
    end
    sqx = $signed(ax_q[0][0]) * $signed(ax_q[0][0]);
    sqy = $signed(ax_q[0][1]) * $signed(ax_q[0][1]);
    sqz = $signed(ax_q[0][2]) * $signed(ax_q[0][2]);
  end

  // degrees to radians: split constant ratio into integer and fractional parts,
  // fraction divided by 23040 = 512 * 45 via shift and reciprocal multiply
  always_comb begin
    am     = ang1_q[14] ? 15'(-ang1_q) : 15'(ang1_q);
    mag    = am[13:0];
    n2_sum = 32'(sq1_q[0]) + 32'(sq1_q[1]) + 32'(sq1_q[2]);
    th     = hi3_q + 32'(p3_q[38:25]);
    th_s   = $signed({2'b00, th});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang0_q <= angle_deg_i;
      ax_q[0] <= {axis_z_i, axis_y_i, axis_x_i};
      for (int k = 1; k <= ST_U; k++) ax_q[k] <= ax_q[k-1];

      ang1_q    <= aw[14:0];
      flip_q[1] <= flp;
      sq1_q[0]  <= sqx[30:0];
      sq1_q[1]  <= sqy[30:0];
      sq1_q[2]  <= sqz[30:0];
      for (int k = 2; k <= ST_CS; k++) flip_q[k] <= flip_q[k-1];

      hi2_q  <= 32'(mag) * 32'd146408;
      lo2_q  <= 28'(mag) * 28'd19106 + 28'd11520;
      neg2_q <= ang1_q[14];
      n2_q[ST_N2]   <= n2_sum;
      zero_q[ST_N2] <= (n2_sum == 32'd0);
      for (int k = ST_N2 + 1; k <= ST_N2 + 15; k++) n2_q[k] <= n2_q[k-1];
      for (int k = ST_N2 + 1; k <= ST_U; k++) zero_q[k] <= zero_q[k-1];

      p3_q   <= 39'(lo2_q[27:9]) * 39'd745655;
      hi3_q  <= hi2_q;
      neg3_q <= neg2_q;

      c4_q.x <= GAIN_Q30;
      c4_q.y <= '0;
      c4_q.z <= neg3_q ? -th_s : th_s;
    end
  end

  // CORDIC row
  cordic_t cd [0:CORDIC_N];
  assign cd[0] = c4_q;

  for (genvar k = 0; k < CORDIC_N; k++) begin : g_cordic
    aarm_cordic_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (en),
      .shift_i (5'(k)),
      .atan_i  (atan_q30(5'(k))),
      .cell_i  (cd[k]),
      .cell_o  (cd[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cs_q[ST_CS+1].c <= flip_q[ST_CS] ? -cd[CORDIC_N].x : cd[CORDIC_N].x;
      cs_q[ST_CS+1].s <= flip_q[ST_CS] ? -cd[CORDIC_N].y : cd[CORDIC_N].y;
      for (int k = ST_CS + 2; k <= ST_U; k++) cs_q[k] <= cs_q[k-1];
    end
  end

  // square root of n2 * 2^32; low half of the radicand is zero
  sqrt_t sq [0:SQ_N];
  assign sq[0] = '0;

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    logic [1:0] pair;
    if (k < 16) begin : g_hi
      assign pair = n2_q[ST_N2+k][31-2*k -: 2];
    end else begin : g_lo
      assign pair = 2'b00;
    end
    aarm_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .pair_i (pair),
      .cell_i (sq[k]),
      .cell_o (sq[k+1])
    );
  end

  // divisor travels beside the divider row
  logic [31:0] r_w  [0:DIV_N-1];
  logic [31:0] rd_q [1:DIV_N-1];
  assign r_w[0] = sq[SQ_N].root;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_q[1] <= r_w[0];
      for (int k = 2; k <= DIV_N - 1; k++) rd_q[k] <= rd_q[k-1];
    end
  end

  for (genvar k = 1; k < DIV_N; k++) begin : g_rd
    assign r_w[k] = rd_q[k];
  end

  // |v| * 2^46 + r/2 divided by r; dividend low bits are r >> 1
  div_t dv [3][0:DIV_N];

  for (genvar j = 0; j < 3; j++) begin : g_comp
    logic [15:0] vmag;
    assign vmag     = ax_q[ST_R][j][15] ? 16'(-ax_q[ST_R][j]) : ax_q[ST_R][j];
    assign dv[j][0] = '{rem: {1'b0, vmag, 15'b0}, quo: '0};
    for (genvar k = 0; k < DIV_N; k++) begin : g_div
      aarm_div_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .bit_i  (r_w[k][31-k]),
        .div_i  (r_w[k]),
        .cell_i (dv[j][k]),
        .cell_o (dv[j][k+1])
      );
    end
  end

  // products
  cq_t  u [3];
  cq_t  pp_q [6];
  cq_t  us_q [3];
  cq_t  t_q, c1_q, c2_q;
  logic zero1_q, zero2_q;
  cq_t  ppt_q [6];
  cq_t  us2_q [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      u[j] = ax_q[ST_U][j][15] ? -$signed({3'b000, dv[j][DIV_N].quo})
                               : $signed({3'b000, dv[j][DIV_N].quo});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pp_q[0] <= mulq(u[0], u[0]);
      pp_q[1] <= mulq(u[0], u[1]);
      pp_q[2] <= mulq(u[0], u[2]);
      pp_q[3] <= mulq(u[1], u[1]);
      pp_q[4] <= mulq(u[1], u[2]);
      pp_q[5] <= mulq(u[2], u[2]);
      for (int j = 0; j < 3; j++) us_q[j] <= mulq(u[j], cs_q[ST_U].s);
      t_q     <= ONE_Q30 - cs_q[ST_U].c;
      c1_q    <= cs_q[ST_U].c;
      zero1_q <= zero_q[ST_U];

      for (int j = 0; j < 6; j++) ppt_q[j] <= mulq(pp_q[j], t_q);
      for (int j = 0; j < 3; j++) us2_q[j] <= us_q[j];
      c2_q    <= c1_q;
      zero2_q <= zero1_q;
    end
  end

  res_t res;

  always_comb begin
    res.zero = zero2_q;
    if (zero2_q) begin
      res.m = '0;
      res.m[0] = ONE_Q14;
      res.m[4] = ONE_Q14;
      res.m[8] = ONE_Q14;
    end else begin
      res.m[0] = to_q14(ppt_q[0], c2_q,     1'b0);
      res.m[1] = to_q14(ppt_q[1], us2_q[2], 1'b0);
      res.m[2] = to_q14(ppt_q[2], us2_q[1], 1'b1);
      res.m[3] = to_q14(ppt_q[1], us2_q[2], 1'b1);
      res.m[4] = to_q14(ppt_q[3], c2_q,     1'b0);
      res.m[5] = to_q14(ppt_q[4], us2_q[0], 1'b0);
      res.m[6] = to_q14(ppt_q[2], us2_q[1], 1'b0);
      res.m[7] = to_q14(ppt_q[4], us2_q[0], 1'b1);
      res.m[8] = to_q14(ppt_q[5], c2_q,     1'b0);
    end
  end

  // output register and skid entry
  assign out_free = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= v_q[LAST];
      end
    end else if (!skid_v_q && v_q[LAST]) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) out_q <= skid_v_q ? skid_q : res;
    if (!out_free && !skid_v_q) skid_q <= res;
  end

  assign out_valid_o = out_v_q;
  assign m00_o       = out_q.m[0];
  assign m01_o       = out_q.m[1];
  assign m02_o       = out_q.m[2];
  assign m10_o       = out_q.m[3];
  assign m11_o       = out_q.m[4];
  assign m12_o       = out_q.m[5];
  assign m20_o       = out_q.m[6];
  assign m21_o       = out_q.m[7];
  assign m22_o       = out_q.m[8];
  assign axis_zero_o = out_q.zero;

  `AARM_ASSERT_NEVER(a_skid_without_out, clk_i, rst_ni, skid_v_q && !out_v_q,
    "skid entry holds a beat while output register is empty")
  `AARM_ASSERT(a_skid_fill_on_hold, clk_i, rst_ni,
    $rose(skid_v_q) |-> $past(out_v_q && out_stall_i), "skid filled without output hold")
  `AARM_ASSERT(a_zero_identity, clk_i, rst_ni,
    out_v_q && out_q.zero |-> out_q.m[0] == ONE_Q14 && out_q.m[1] == 16'd0
      && out_q.m[8] == ONE_Q14,
    "zero axis result is not identity")

endmodule

// ===== rtl/core/aarm_cordic_cell.sv =====
// One rotation-mode CORDIC micro-rotation with its output register
`timescale 1ns / 1ps

module aarm_cordic_cell (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [4:0]        shift_i,
  input  logic [29:0]       atan_i,
  input  aarm_pkg::cordic_t cell_i,
  output aarm_pkg::cordic_t cell_o
);
  import aarm_pkg::*;

  cordic_t cell_d, cell_q;
  cq_t     dx, dy, at;

  always_comb begin
    dx = $signed(cell_i.y) >>> shift_i;
    dy = $signed(cell_i.x) >>> shift_i;
    at = $signed({4'b0000, atan_i});
    if (!cell_i.z[XW-1]) begin
      cell_d.x = cell_i.x - dx;
      cell_d.y = cell_i.y + dy;
      cell_d.z = cell_i.z - at;
    end else begin
      cell_d.x = cell_i.x + dx;
      cell_d.y = cell_i.y - dy;
      cell_d.z = cell_i.z + at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

// ===== rtl/core/aarm_sqrt_cell.sv =====
// One digit of the restoring square root, two radicand bits per cell
`timescale 1ns / 1ps

module aarm_sqrt_cell (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [1:0]      pair_i,
  input  aarm_pkg::sqrt_t cell_i,
  output aarm_pkg::sqrt_t cell_o
);
  import aarm_pkg::*;

  sqrt_t       cell_d, cell_q;
  logic [35:0] rem_sh, trial, diff;

  always_comb begin
    rem_sh = {cell_i.rem, pair_i};
    trial  = {2'b00, cell_i.root, 2'b01};
    diff   = rem_sh - trial;
    if (rem_sh >= trial) begin
      cell_d.rem  = diff[33:0];
      cell_d.root = {cell_i.root[30:0], 1'b1};
    end else begin
      cell_d.rem  = rem_sh[33:0];
      cell_d.root = {cell_i.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

// ===== rtl/core/aarm_div_cell.sv =====
// One quotient bit of the restoring divider
`timescale 1ns / 1ps

module aarm_div_cell (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic           bit_i,
  input  logic [31:0]    div_i,
  input  aarm_pkg::div_t cell_i,
  output aarm_pkg::div_t cell_o
);
  import aarm_pkg::*;

  div_t        cell_d, cell_q;
  logic [32:0] sh, dv, diff;

  always_comb begin
    sh   = {cell_i.rem, bit_i};
    dv   = {1'b0, div_i};
    diff = sh - dv;
    if (sh >= dv) begin
      cell_d.rem = diff[31:0];
      cell_d.quo = {cell_i.quo[29:0], 1'b1};
    end else begin
      cell_d.rem = sh[31:0];
      cell_d.quo = {cell_i.quo[29:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

// ===== tb/axis_angle_rotation_matrix_top_tb.sv =====
// Testbench for the axis-angle rotation matrix block: directed table, random beats, predictor
`timescale 1ns / 1ps

module axis_angle_rotation_matrix_top_tb;
  import aarm_pkg::*;

  typedef struct {
    logic signed [15:0] m [9];
    logic               zero;
  } coeffs_t;

  typedef struct {
    logic signed [16:0] angle;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    bit                 typed;  // identity typed in below
  } row_t;

  localparam int    PERIOD  = 12;
  localparam int    N_RAND  = 1130;
  localparam int    DRAIN   = 120;
  localparam longint ONE_Q30  = 64'sd1 << 30;
  localparam longint HALF_T   = 23040;
  localparam longint QUART_T  = 11520;
  localparam longint PI_Q30   = 64'sd3373259426;
  localparam longint GAIN     = 64'sd652032874;
  localparam longint ATAN_TBL [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
  localparam string FNAME [9] = '{"m00", "m01", "m02", "m10", "m11", "m12",
                                  "m20", "m21", "m22"};

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [16:0] angle_deg_i;
  logic signed [15:0] axis_x_i;
  logic signed [15:0] axis_y_i;
  logic signed [15:0] axis_z_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [15:0] m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o;
  logic               axis_zero_o;

  coeffs_t pending_mats [$];
  int      n_fail;
  int      rx_wait;
  bit      rx_burst;

  axis_angle_rotation_matrix_top dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #(PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(PERIOD * 600000);
    $display("** axis_angle_rotation_matrix_top: FAILED **");
    $finish;
  end

  function automatic longint round_q30(longint a, longint b);
    return (a * b + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt  = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic longint unit_q30(longint v, longint unsigned r);
    longint unsigned mag, q;
    mag = (v < 0) ? -v : v;
    q   = ((mag << 46) + r / 2) / r;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [15:0] to_q14(longint v);
    longint q;
    q = (v + (64'sd1 << 15)) >>> 16;
    if (q > 16384) q = 16384;
    if (q < -16384) q = -16384;
    return q[15:0];
  endfunction

  function automatic coeffs_t identity_mat();
    coeffs_t r;
    for (int i = 0; i < 9; i++) r.m[i] = (i % 4 == 0) ? 16'sd16384 : 16'sd0;
    r.zero = 1'b1;
    return r;
  endfunction

  function automatic coeffs_t rotation_of(logic signed [16:0] ang, logic signed [15:0] x,
                                          logic signed [15:0] y, logic signed [15:0] z);
    coeffs_t r;
    longint a, vx, vy, vz, th, cx, cy, cz, dx, dy, c, s, ux, uy, uz, t;
    longint mm [9];
    longint unsigned n2, rt;
    bit flip;
    a  = longint'(ang);
    vx = longint'(x);
    vy = longint'(y);
    vz = longint'(z);
    n2 = vx * vx + vy * vy + vz * vz;
    if (n2 == 0) return identity_mat();
    flip = 0;
    while (a >= HALF_T) a -= 2 * HALF_T;
    while (a < -HALF_T) a += 2 * HALF_T;
    if (a > QUART_T) begin
      a -= HALF_T;
      flip = 1;
    end else if (a < -QUART_T) begin
      a += HALF_T;
      flip = 1;
    end
    th = ((((a < 0) ? -a : a) * PI_Q30) + HALF_T / 2) / HALF_T;
    cx = GAIN;
    cy = 0;
    cz = (a < 0) ? -th : th;
    for (int i = 0; i < CORDIC_N; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cz >= 0) begin
        cx -= dx; cy += dy; cz -= ATAN_TBL[i];
      end else begin
        cx += dx; cy -= dy; cz += ATAN_TBL[i];
      end
    end
    c  = flip ? -cx : cx;
    s  = flip ? -cy : cy;
    rt = int_sqrt(n2 << 32);
    ux = unit_q30(vx, rt);
    uy = unit_q30(vy, rt);
    uz = unit_q30(vz, rt);
    t  = ONE_Q30 - c;
    mm[0] = round_q30(round_q30(ux, ux), t) + c;
    mm[1] = round_q30(round_q30(ux, uy), t) + round_q30(uz, s);
    mm[2] = round_q30(round_q30(ux, uz), t) - round_q30(uy, s);
    mm[3] = round_q30(round_q30(ux, uy), t) - round_q30(uz, s);
    mm[4] = round_q30(round_q30(uy, uy), t) + c;
    mm[5] = round_q30(round_q30(uy, uz), t) + round_q30(ux, s);
    mm[6] = round_q30(round_q30(ux, uz), t) + round_q30(uy, s);
    mm[7] = round_q30(round_q30(uy, uz), t) - round_q30(ux, s);
    mm[8] = round_q30(round_q30(uz, uz), t) + c;
    for (int i = 0; i < 9; i++) r.m[i] = to_q14(mm[i]);
    r.zero = 1'b0;
    return r;
  endfunction

  // one beat: gap, present, hold until taken, then queue its expectation
  task automatic send_beat(logic signed [16:0] ang, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z,
                           int gap, coeffs_t expd);
    repeat (gap) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    angle_deg_i = ang;
    axis_x_i    = x;
    axis_y_i    = y;
    axis_z_i    = z;
    do @(posedge clk_i); while (in_stall_o);
    pending_mats.push_back(expd);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // output side: check each taken beat, then draw the next stall run
  always @(posedge clk_i) begin
    coeffs_t e;
    logic signed [15:0] got [9];
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o};
      if (pending_mats.size() == 0) begin
        $error("result beat with nothing expected");
        n_fail++;
      end else begin
        e = pending_mats.pop_front();
        for (int i = 0; i < 9; i++)
          if (got[i] !== e.m[i]) begin
            $error("%s: expected %0d, got %0d", FNAME[i], e.m[i], got[i]);
            n_fail++;
          end
        if (axis_zero_o !== e.zero) begin
          $error("axis_zero: expected %0d, got %0d", e.zero, axis_zero_o);
          n_fail++;
        end
      end
      if ($urandom_range(0, 99) < 3) rx_burst = !rx_burst;
      rx_wait = rx_burst ? 0 : int'($urandom_range(0, 5));
    end
  end

  always @(negedge clk_i) begin
    if (rx_wait > 0) begin
      out_stall_i <= 1'b1;
      rx_wait     <= rx_wait - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    row_t    dir_rows [$];
    row_t    rw;
    coeffs_t expd;
    logic signed [16:0] ang;
    logic signed [15:0] x, y, z;
    int      gap, kind, waited;
    bit      tx_burst;

    n_fail      = 0;
    rx_wait     = 0;
    rx_burst    = 0;
    tx_burst    = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    out_stall_i = 1'b0;
    angle_deg_i = '0;
    axis_x_i    = '0;
    axis_y_i    = '0;
    axis_z_i    = '0;

    dir_rows = '{
      '{17'sd0,      16'sd0,      16'sd0,      16'sd0,      1'b1},  // zero axis
      '{17'sd46080,  16'sd0,      16'sd0,      16'sd0,      1'b1},
      '{17'sh10000,  16'sd0,      16'sd0,      16'sd0,      1'b1},
      '{17'sd0,      16'sd1,      16'sd0,      16'sd0,      1'b0},
      '{17'sd11520,  16'sd0,      16'sd0,      16'sd1,      1'b0},  // quarter turn edge
      '{17'sd11521,  16'sd0,      16'sd0,      16'sd1,      1'b0},
      '{-17'sd11520, 16'sd0,      16'sd1,      16'sd0,      1'b0},
      '{-17'sd11521, 16'sd0,      16'sd1,      16'sd0,      1'b0},
      '{17'sd23040,  16'sd1,      16'sd0,      16'sd0,      1'b0},  // half turn
      '{-17'sd23040, 16'sd1,      16'sd0,      16'sd0,      1'b0},
      '{17'sd23039,  16'sd0,      16'sd0,      -16'sd5,     1'b0},
      '{17'sd34560,  16'sd3,      16'sd4,      16'sd0,      1'b0},
      '{17'sd46080,  16'sd1,      16'sd1,      16'sd1,      1'b0},
      '{-17'sd46080, 16'sd1,      -16'sd1,     16'sd1,      1'b0},
      '{17'sd65535,  16'sd32767,  16'sd32767,  16'sd32767,  1'b0},  // wraps past 360
      '{17'sh10000,  16'sh8000,   16'sh8000,   16'sh8000,   1'b0},
      '{17'sd5760,   16'sh8000,   16'sd0,      16'sd0,      1'b0},
      '{17'sd3840,   16'sd0,      16'sd32767,  16'sh8000,   1'b0},
      '{-17'sd1,     16'sd1,      16'sd2,      16'sd2,      1'b0},
      '{17'sd1,      -16'sd1,     16'sd1,      -16'sd1,     1'b0},
      '{17'sd7680,   16'sd12345,  -16'sd321,   16'sd7,      1'b0}
    };

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      rw   = dir_rows[i];
      expd = rw.typed ? identity_mat() : rotation_of(rw.angle, rw.ax, rw.ay, rw.az);
      send_beat(rw.angle, rw.ax, rw.ay, rw.az, int'($urandom_range(0, 5)), expd);
    end

    for (int n = 0; n < N_RAND; n++) begin
      // hold off until the pipe has drained, then go on
      if (n == N_RAND / 2) begin
        while (pending_mats.size() != 0) @(negedge clk_i);
      end
      kind = int'($urandom_range(0, 99));
      if (kind < 85) ang = 17'($urandom_range(0, 92160) - 46080);
      else           ang = 17'($urandom());
      kind = int'($urandom_range(0, 99));
      if (kind < 4) begin
        x = '0; y = '0; z = '0;
      end else if (kind < 45) begin
        x = 16'($urandom()); y = 16'($urandom()); z = 16'($urandom());
      end else if (kind < 75) begin
        x = 16'($urandom_range(0, 200) - 100);
        y = 16'($urandom_range(0, 200) - 100);
        z = 16'($urandom_range(0, 200) - 100);
      end else if (kind < 90) begin
        x = '0; y = '0; z = '0;
        case ($urandom_range(0, 2))
          0: x = 16'($urandom());
          1: y = 16'($urandom());
          default: z = 16'($urandom());
        endcase
      end else begin
        x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        z = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end
      if ($urandom_range(0, 99) < 3) tx_burst = !tx_burst;
      gap = tx_burst ? 0 : int'($urandom_range(0, 5));
      send_beat(ang, x, y, z, gap, rotation_of(ang, x, y, z));
    end

    waited = 0;
    while (pending_mats.size() != 0 && waited < 100000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (DRAIN) @(negedge clk_i);
    if (pending_mats.size() != 0) begin
      $error("%0d expected results never arrived", pending_mats.size());
      n_fail++;
    end
    if (n_fail == 0) $display("** axis_angle_rotation_matrix_top: PASSED **");
    else $display("** axis_angle_rotation_matrix_top: FAILED **");
    $finish;
  end

endmodule

// ===== axis_angle_rotation_matrix_top.f =====
+incdir+rtl/core
rtl/core/aarm_pkg.sv
rtl/core/aarm_cordic_cell.sv
rtl/core/aarm_sqrt_cell.sv
rtl/core/aarm_div_cell.sv
rtl/core/axis_angle_rotation_matrix_top.sv
tb/axis_angle_rotation_matrix_top_tb.sv
